// File: hdl/slh_pkg.sv
// Shared types, constants and round functions for the salted 256-bit key hash.
package slh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned HashW    = 64;

  localparam logic [IdxW-1:0] LastSaltIdx = IdxW'(NumWords - 1);

  // seed: 0xdeadbeef plus key length in bytes
  localparam logic [WordW-1:0] SeedBase = 32'hdeadbeef;
  localparam logic [WordW-1:0] KeyBytes = 32'd32;
  localparam logic [WordW-1:0] LaneInit = SeedBase + KeyBytes;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] key_words_t;
  typedef word_t [4:0] mid_words_t;
  typedef word_t [1:0] tail_words_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } lanes_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

  // first three steps of the mix round
  function automatic lanes_t mix_lo(input lanes_t l);
    word_t x, y, z;
    x = l.a; y = l.b; z = l.c;
    x = x - z; x = x ^ rotl(z, 4);  z = z + y;
    y = y - x; y = y ^ rotl(x, 6);  x = x + z;
    z = z - y; z = z ^ rotl(y, 8);  y = y + x;
    mix_lo = '{a: x, b: y, c: z};
  endfunction

  // last three steps of the mix round
  function automatic lanes_t mix_hi(input lanes_t l);
    word_t x, y, z;
    x = l.a; y = l.b; z = l.c;
    x = x - z; x = x ^ rotl(z, 16); z = z + y;
    y = y - x; y = y ^ rotl(x, 19); x = x + z;
    z = z - y; z = z ^ rotl(y, 4);  y = y + x;
    mix_hi = '{a: x, b: y, c: z};
  endfunction

  // first four steps of the final round
  function automatic lanes_t final_lo(input lanes_t l);
    word_t x, y, z;
    x = l.a; y = l.b; z = l.c;
    z = z ^ y; z = z - rotl(y, 14);
    x = x ^ z; x = x - rotl(z, 11);
    y = y ^ x; y = y - rotl(x, 25);
    z = z ^ y; z = z - rotl(y, 16);
    final_lo = '{a: x, b: y, c: z};
  endfunction

  // last three steps of the final round
  function automatic lanes_t final_hi(input lanes_t l);
    word_t x, y, z;
    x = l.a; y = l.b; z = l.c;
    x = x ^ z; x = x - rotl(z, 4);
    y = y ^ x; y = y - rotl(x, 14);
    z = z ^ y; z = z - rotl(y, 24);
    final_hi = '{a: x, b: y, c: z};
  endfunction

endpackage

// File: hdl/slh_pipe.sv
// Seven-stage hash pipeline: lane seeding, two mix rounds and the final round.
module slh_pipe import slh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  key_words_t         words_i,
  output logic               out_valid_o,
  output logic [HashW-1:0]   hash_o
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] valid_q, valid_d;

  lanes_t      l1_q, l2_q, l3_q, l4_q, l5_q, l6_q, l7_q;
  lanes_t      l1_d, l2_d, l3_d, l4_d, l5_d, l6_d, l7_d;
  mid_words_t  m1_q, m2_q;
  tail_words_t t3_q, t4_q;

  assign valid_d = {valid_q[Stages-2:0], in_valid_i};

  always_comb begin
    l1_d = '{a: LaneInit + words_i[0], b: LaneInit + words_i[1], c: LaneInit + words_i[2]};
    l2_d = mix_lo(l1_q);
    l3_d = mix_hi(l2_q);
    l3_d.a = l3_d.a + m2_q[0];
    l3_d.b = l3_d.b + m2_q[1];
    l3_d.c = l3_d.c + m2_q[2];
    l4_d = mix_lo(l3_q);
    l5_d = mix_hi(l4_q);
    l5_d.a = l5_d.a + t4_q[0];
    l5_d.b = l5_d.b + t4_q[1];
    l6_d = final_lo(l5_q);
    l7_d = final_hi(l6_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload registers load every cycle; valid bits mark live words
  always_ff @(posedge clk_i) begin
    l1_q <= l1_d;
    m1_q <= words_i[7:3];
    l2_q <= l2_d;
    m2_q <= m1_q;
    l3_q <= l3_d;
    t3_q <= m2_q[4:3];
    l4_q <= l4_d;
    t4_q <= t3_q;
    l5_q <= l5_d;
    l6_q <= l6_d;
    l7_q <= l7_d;
  end

  assign out_valid_o = valid_q[Stages-1];
  assign hash_o      = {l7_q.b, l7_q.c};

endmodule

// File: hdl/salted_lookup3_hash_256_top.sv
// Top level of the salted 256-bit key hash: salt registers and pipeline.
//
// Usage:
//   Configuration: cfg_we_i writes cfg_wdata_i into salt word cfg_idx_i
//   (0..7) at the clock edge; indexes 8 and above are ignored. Write only
//   while no words are in flight.
//   Input: a key word of eight 32-bit little-endian words is taken at each
//   edge where start_i is high and busy_o is low. busy_o is always low, so
//   a new key can be given in every cycle.
//   Output: done_o is high for one cycle with hash_value_o (lane b above
//   lane c) after the key has passed all stages. One result per key, in order.
//   Throughput: one key per cycle. Latency is set by the seven register
//   stages: seeding, two per mix round (three steps each), and the final
//   round split four steps and three steps.
//   The salt is applied at acceptance, from the registers as they stand.
//   Reset: clears the salt registers and all pipeline valid bits; words in
//   flight are dropped. The receiver cannot stall; no back-pressure exists.
module salted_lookup3_hash_256_top import slh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [WordW-1:0]  cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [WordW-1:0]  data_word0_i,
  input  logic [WordW-1:0]  data_word1_i,
  input  logic [WordW-1:0]  data_word2_i,
  input  logic [WordW-1:0]  data_word3_i,
  input  logic [WordW-1:0]  data_word4_i,
  input  logic [WordW-1:0]  data_word5_i,
  input  logic [WordW-1:0]  data_word6_i,
  input  logic [WordW-1:0]  data_word7_i,
  output logic              done_o,
  output logic [HashW-1:0]  hash_value_o
);

  key_words_t salt_q;
  key_words_t data_w, salted_w;
  logic       accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign data_w = {data_word7_i, data_word6_i, data_word5_i, data_word4_i,
                   data_word3_i, data_word2_i, data_word1_i, data_word0_i};
  assign salted_w = data_w ^ salt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i <= LastSaltIdx)) begin
      salt_q[cfg_idx_i[$clog2(NumWords)-1:0]] <= cfg_wdata_i;
    end
  end

  slh_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .words_i     (salted_w),
    .out_valid_o (done_o),
    .hash_o      (hash_value_o)
  );

endmodule

// File: test/tb_top.sv
// Testbench for salted_lookup3_hash_256_top: scoreboard class, drivers, monitor and watchdog.
`timescale 1ns / 100ps

module tb_top;
  import slh_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseItems  = 265;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned MaxPrints   = 50;

  typedef enum int unsigned {
    SaltRandom,
    SaltZero,
    SaltOnes,
    SaltPartial,
    SaltStripes
  } salt_mode_e;

  class hash_scoreboard;
    word_t            salt[NumWords];
    logic [HashW-1:0] expected_hashes[$];
    int unsigned      errors;

    function new();
      foreach (salt[i]) salt[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction

    function word_t rot_left(word_t v, int unsigned s);
      return (v << s) | (v >> (WordW - s));
    endfunction

    // keyed hash over the salted key, lane b above lane c
    function logic [HashW-1:0] predict_hash(key_words_t key);
      word_t w[NumWords];
      word_t la, lb, lc;
      foreach (w[i]) w[i] = key[i] ^ salt[i];
      la = 32'hdeadbeef + 32'd32;
      lb = la;
      lc = la;
      for (int grp = 0; grp < 2; grp++) begin
        la += w[3*grp]; lb += w[3*grp+1]; lc += w[3*grp+2];
        la -= lc; la ^= rot_left(lc, 4);  lc += lb;
        lb -= la; lb ^= rot_left(la, 6);  la += lc;
        lc -= lb; lc ^= rot_left(lb, 8);  lb += la;
        la -= lc; la ^= rot_left(lc, 16); lc += lb;
        lb -= la; lb ^= rot_left(la, 19); la += lc;
        lc -= lb; lc ^= rot_left(lb, 4);  lb += la;
      end
      la += w[6]; lb += w[7];
      lc ^= lb; lc -= rot_left(lb, 14);
      la ^= lc; la -= rot_left(lc, 11);
      lb ^= la; lb -= rot_left(la, 25);
      lc ^= lb; lc -= rot_left(lb, 16);
      la ^= lc; la -= rot_left(lc, 4);
      lb ^= la; lb -= rot_left(la, 14);
      lc ^= lb; lc -= rot_left(lb, 24);
      return {lb, lc};
    endfunction

    function void note_salt_write(logic [IdxW-1:0] idx, word_t value);
      if (idx <= LastSaltIdx) salt[idx] = value;
    endfunction

    function void note_key(key_words_t key);
      expected_hashes.push_back(predict_hash(key));
    endfunction

    task report(string msg);
      if (errors < MaxPrints) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_hash(logic [HashW-1:0] got);
      logic [HashW-1:0] want;
      if (expected_hashes.size() == 0) begin
        report($sformatf("hash_value %016h with no word pending", got));
      end else begin
        want = expected_hashes.pop_front();
        if (got !== want)
          report($sformatf("hash_value got %016h expected %016h", got, want));
      end
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i = '0;
  logic [WordW-1:0] cfg_wdata_i = '0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [WordW-1:0] data_word0_i = '0;
  logic [WordW-1:0] data_word1_i = '0;
  logic [WordW-1:0] data_word2_i = '0;
  logic [WordW-1:0] data_word3_i = '0;
  logic [WordW-1:0] data_word4_i = '0;
  logic [WordW-1:0] data_word5_i = '0;
  logic [WordW-1:0] data_word6_i = '0;
  logic [WordW-1:0] data_word7_i = '0;
  logic             done_o;
  logic [HashW-1:0] hash_value_o;

  hash_scoreboard sb;
  int unsigned    quiet_cycles = 0;

  salted_lookup3_hash_256_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .data_word0_i (data_word0_i),
    .data_word1_i (data_word1_i),
    .data_word2_i (data_word2_i),
    .data_word3_i (data_word3_i),
    .data_word4_i (data_word4_i),
    .data_word5_i (data_word5_i),
    .data_word6_i (data_word6_i),
    .data_word7_i (data_word7_i),
    .done_o       (done_o),
    .hash_value_o (hash_value_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // monitor: key taken before a same-edge salt write, as the block does
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_key({data_word7_i, data_word6_i, data_word5_i, data_word4_i,
                     data_word3_i, data_word2_i, data_word1_i, data_word0_i});
      if (cfg_we_i) sb.note_salt_write(cfg_idx_i, cfg_wdata_i);
      if (done_o) sb.check_hash(hash_value_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_key(input key_words_t key);
    start_i      <= 1'b1;
    data_word0_i <= key[0];
    data_word1_i <= key[1];
    data_word2_i <= key[2];
    data_word3_i <= key[3];
    data_word4_i <= key[4];
    data_word5_i <= key[5];
    data_word6_i <= key[6];
    data_word7_i <= key[7];
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // one edge first so the last accepted word is already queued
  task automatic drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_salt(input key_words_t value, input logic [NumWords-1:0] mask);
    for (int i = 0; i < NumWords; i++) begin
      if (mask[i]) begin
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= IdxW'(i);
        cfg_wdata_i <= value[i];
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // indexes past the last salt word must leave the salt alone
  task automatic write_unused_indexes();
    for (int i = NumWords; i < (1 << IdxW); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= IdxW'(i);
      cfg_wdata_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, WordW - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic key_words_t rand_key();
    key_words_t key;
    foreach (key[i]) key[i] = rand_word();
    return key;
  endfunction

  function automatic key_words_t fill_key(input word_t value);
    key_words_t key;
    foreach (key[i]) key[i] = value;
    return key;
  endfunction

  task automatic send_stream(input int unsigned count);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 32);
    for (int n = 0; n < count; n++) begin
      send_key(rand_key());
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) pause(gap);
        burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 32);
      end
    end
    start_i <= 1'b0;
  endtask

  initial begin
    key_words_t         salt_val;
    key_words_t         key;
    logic [NumWords-1:0] mask;
    salt_mode_e         mode;

    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under the reset salt
    send_key(fill_key('0));
    send_key(fill_key('1));
    send_key(fill_key(32'haaaaaaaa));
    send_key(fill_key(32'h55555555));
    send_key(fill_key(32'h80000000));
    send_key(fill_key(32'h00000001));
    for (int i = 0; i < NumWords; i++) begin
      key    = '0;
      key[i] = '1;
      send_key(key);
    end
    start_i <= 1'b0;
    drain();

    // all-ones salt: an all-ones key salts down to zero
    program_salt(fill_key('1), '1);
    send_key(fill_key('0));
    send_key(fill_key('1));
    send_key(rand_key());
    start_i <= 1'b0;
    drain();

    write_unused_indexes();
    send_key(fill_key('1));
    send_key(rand_key());
    start_i <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      mode = salt_mode_e'(ph % 5);
      mask = '1;
      case (mode)
        SaltRandom:  foreach (salt_val[i]) salt_val[i] = $urandom;
        SaltZero:    salt_val = '0;
        SaltOnes:    salt_val = fill_key('1);
        SaltPartial: begin
          foreach (salt_val[i]) salt_val[i] = rand_word();
          mask = NumWords'($urandom);
        end
        default:     foreach (salt_val[i]) salt_val[i] = i[0] ? 32'h55555555 : 32'haaaaaaaa;
      endcase
      program_salt(salt_val, mask);
      if ($urandom_range(0, 2) == 0) write_unused_indexes();
      send_stream(PhaseItems);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
